// ===== sv/sceq_pkg.sv =====
// ----------------------------------------------------------------------------
// sceq_pkg
// Shared types and constants of the stereo biquad equaliser: default sizes,
// operation and register codes, coefficient term codes, controller states
// and the command and status records between controller and datapath.
// ----------------------------------------------------------------------------
package sceq_pkg;

    // Default sizes of the storage and arithmetic.
    localparam int unsigned DEF_NUM_BANDS    = 8;
    localparam int unsigned DEF_SAMPLE_WIDTH = 24;
    localparam int unsigned DEF_COEF_WIDTH   = 24;

    // Fixed widths of the external fields.
    localparam int unsigned IO_WIDTH    = 24;
    localparam int unsigned BAND_IN_W   = 3;
    localparam int unsigned COEF_IDX_W  = 3;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 4;
    localparam int unsigned MAX_BAND_W  = 5;
    localparam int unsigned NUM_TERMS   = 5;
    localparam int unsigned TERM_W      = 3;

    // Request operation codes.
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_COEF  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANDS = 1'd1;

    // Configuration reset values.
    localparam logic                  RST_ENABLE       = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_ACTIVE_BANDS = 4'd8;

    // Coefficient term codes, also the order in which the MAC visits them.
    localparam logic [TERM_W-1:0] TERM_B0 = 3'd0;
    localparam logic [TERM_W-1:0] TERM_B1 = 3'd1;
    localparam logic [TERM_W-1:0] TERM_B2 = 3'd2;
    localparam logic [TERM_W-1:0] TERM_A1 = 3'd3;
    localparam logic [TERM_W-1:0] TERM_A2 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_RND,
        ST_WB,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                  load_frame;
        logic                  coef_wr;
        logic                  rd;
        logic [MAX_BAND_W-1:0] band;
        logic                  chan;
        logic                  mul;
        logic [TERM_W-1:0]     term;
        logic                  acc;
        logic                  rnd;
        logic                  wb;
        logic                  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== sv/stereo_cascaded_biquad_eq.sv =====
// A filtered frame runs each band applied through the single shared multiply-accumulate unit,
// once per channel (read, five products, two adds, store); a bypassed frame goes straight to
// the output register. Requests are taken one at a time: a frame holds the input until its
// result is loaded into the output register, and a coefficient write completes in the cycle
// it is accepted.
// Reset: enable 1, eight bands; valid flags clear, so b0 reads as unity and the rest as zero.
// ----------------------------------------------------------------------------
// stereo_cascaded_biquad_eq
// Stereo equaliser made of cascaded direct-form-I biquad sections, one per
// band, with coefficients shared between the left and right channels.
// ----------------------------------------------------------------------------
module stereo_cascaded_biquad_eq #(
    parameter int unsigned NUM_BANDS    = sceq_pkg::DEF_NUM_BANDS,
    parameter int unsigned SAMPLE_WIDTH = sceq_pkg::DEF_SAMPLE_WIDTH,
    parameter int unsigned COEF_WIDTH   = sceq_pkg::DEF_COEF_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Request channel.
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_opcode,
    input  logic signed [sceq_pkg::IO_WIDTH-1:0]   i_left_in,
    input  logic signed [sceq_pkg::IO_WIDTH-1:0]   i_right_in,
    input  logic                                   i_last_frame,
    input  logic [sceq_pkg::BAND_IN_W-1:0]         i_band_index,
    input  logic [sceq_pkg::COEF_IDX_W-1:0]        i_coef_index,
    input  logic signed [sceq_pkg::IO_WIDTH-1:0]   i_coef_value,
    // Result channel.
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [sceq_pkg::IO_WIDTH-1:0]   o_left_out,
    output logic signed [sceq_pkg::IO_WIDTH-1:0]   o_right_out,
    output logic                                   o_last_frame_out,
    output logic                                   o_clipped,
    // Configuration write port.
    input  logic                                   i_cfg_wr_en,
    input  logic [sceq_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sceq_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import sceq_pkg::*;

    // The controller owns the configuration and the band and channel loop;
    // it steps the datapath through one section at a time. For every
    // section the history row of that band and channel is read together
    // with the b0 coefficient of that band, and each further coefficient is
    // read in the cycle before its product. The five products are formed one
    // per cycle and accumulated in a 64-bit saturating accumulator, the
    // rounding constant is added, and the result is saturated to the sample
    // width and written back as the new history.
    //
    // A coefficient write request loads one word and clears both history
    // rows of its band in the same cycle; it produces no result. A write
    // with an out-of-range band or coefficient index is dropped.
    //
    // The finished frame sits in an output register, so the next request is
    // taken while the result still waits to be collected. Only when a second
    // result completes before the first has gone does the controller hold.

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sceq_ctrl #(
        .NUM_BANDS (NUM_BANDS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_band_index (i_band_index),
        .i_coef_index (i_coef_index),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    sceq_dp #(
        .NUM_BANDS    (NUM_BANDS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_left_in        (i_left_in),
        .i_right_in       (i_right_in),
        .i_last_frame     (i_last_frame),
        .i_band_index     (i_band_index),
        .i_coef_index     (i_coef_index),
        .i_coef_value     (i_coef_value),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_last_frame_out (o_last_frame_out),
        .o_clipped        (o_clipped)
    );

    // The datapath steps other than accumulation are issued one kind at a time.
    a_cmd_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_frame, w_cmd.coef_wr, w_cmd.rd, w_cmd.mul,
                  w_cmd.rnd, w_cmd.wb, w_cmd.out_load}))
        else $error("more than one datapath step issued at once");

    // A result is never loaded over one that has not yet been collected.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_status.out_free)
        else $error("result register overwritten while still pending");

    // A memory read is always followed by the first product.
    a_read_then_mul : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd |=> (w_cmd.mul && (w_cmd.term == TERM_B0)))
        else $error("section read not followed by the first product");

    // Rounding only follows the last accumulation of a section.
    a_round_after_acc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rnd |-> $past(w_cmd.acc))
        else $error("rounding step without a preceding accumulation");

endmodule

// ===== sv/sceq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sceq_ctrl
// Sequencer of the equaliser: holds the configuration registers, walks the
// bands and channels of a frame and issues the MAC steps to the datapath.
// ----------------------------------------------------------------------------
module sceq_ctrl #(
    parameter int unsigned NUM_BANDS = sceq_pkg::DEF_NUM_BANDS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_opcode,
    input  logic [sceq_pkg::BAND_IN_W-1:0]       i_band_index,
    input  logic [sceq_pkg::COEF_IDX_W-1:0]      i_coef_index,
    input  logic                                 i_cfg_wr_en,
    input  logic [sceq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sceq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  sceq_pkg::t_dp_status                 i_status,
    output sceq_pkg::t_dp_cmd                    o_cmd
);
    import sceq_pkg::*;

    localparam int unsigned BW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int unsigned NB_W = $clog2(NUM_BANDS + 1);

    t_state                r_state, n_state;
    logic                  r_enable;
    logic [CFG_DATA_W-1:0] r_active_bands;
    logic [BW-1:0]         r_band, n_band;
    logic                  r_chan, n_chan;
    logic [TERM_W-1:0]     r_term, n_term;

    logic                  in_acc;
    logic                  coef_ok;
    logic [NB_W-1:0]       band_lim;
    logic                  filt;
    logic                  last_band;

    assign in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign coef_ok = (32'(i_band_index) < NUM_BANDS) && (i_coef_index <= TERM_A2);

    always_comb begin
        if (32'(r_active_bands) > NUM_BANDS) begin
            band_lim = NB_W'(NUM_BANDS);
        end else begin
            band_lim = NB_W'(r_active_bands);
        end
    end

    assign filt      = r_enable && (band_lim != '0);
    assign last_band = ((NB_W'(r_band) + NB_W'(1)) == band_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_enable       <= RST_ENABLE;
            r_active_bands <= RST_ACTIVE_BANDS;
            r_band         <= '0;
            r_chan         <= 1'b0;
            r_term         <= TERM_B0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
            r_chan  <= n_chan;
            r_term  <= n_term;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ENABLE:       r_enable       <= i_cfg_data[0];
                    CFG_ACTIVE_BANDS: r_active_bands <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Next state and loop counters.
    always_comb begin
        n_state = r_state;
        n_band  = r_band;
        n_chan  = r_chan;
        n_term  = r_term;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_opcode == OP_FRAME)) begin
                    n_band  = '0;
                    n_chan  = 1'b0;
                    n_state = filt ? ST_READ : ST_OUT;
                end
            end
            ST_READ: begin
                n_term  = TERM_B0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_term == TERM_A2) begin
                    n_state = ST_ACC;
                end else begin
                    n_term = r_term + TERM_W'(1);
                end
            end
            ST_ACC: n_state = ST_RND;
            ST_RND: n_state = ST_WB;
            ST_WB: begin
                if (!r_chan) begin
                    n_chan  = 1'b1;
                    n_state = ST_READ;
                end else if (last_band) begin
                    n_state = ST_OUT;
                end else begin
                    n_chan  = 1'b0;
                    n_band  = r_band + BW'(1);
                    n_state = ST_READ;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd      = '0;
        o_cmd.band = MAX_BAND_W'(r_band);
        o_cmd.chan = r_chan;
        o_cmd.term = r_term;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_frame = in_acc && (i_opcode == OP_FRAME);
                o_cmd.coef_wr    = in_acc && (i_opcode == OP_COEF) && coef_ok;
            end
            ST_READ: o_cmd.rd = 1'b1;
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.acc = (r_term != TERM_B0);
            end
            ST_ACC:  o_cmd.acc      = 1'b1;
            ST_RND:  o_cmd.rnd      = 1'b1;
            ST_WB:   o_cmd.wb       = 1'b1;
            ST_OUT:  o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== sv/sceq_dp.sv =====
// ----------------------------------------------------------------------------
// sceq_dp
// Datapath of the equaliser: coefficient and history memories, the shared
// multiply-accumulate unit with rounding and saturation, and the output
// register.
// ----------------------------------------------------------------------------
module sceq_dp #(
    parameter int unsigned NUM_BANDS    = sceq_pkg::DEF_NUM_BANDS,
    parameter int unsigned SAMPLE_WIDTH = sceq_pkg::DEF_SAMPLE_WIDTH,
    parameter int unsigned COEF_WIDTH   = sceq_pkg::DEF_COEF_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sceq_pkg::t_dp_cmd                      i_cmd,
    output sceq_pkg::t_dp_status                   o_status,
    input  logic signed [sceq_pkg::IO_WIDTH-1:0]   i_left_in,
    input  logic signed [sceq_pkg::IO_WIDTH-1:0]   i_right_in,
    input  logic                                   i_last_frame,
    input  logic [sceq_pkg::BAND_IN_W-1:0]         i_band_index,
    input  logic [sceq_pkg::COEF_IDX_W-1:0]        i_coef_index,
    input  logic signed [sceq_pkg::IO_WIDTH-1:0]   i_coef_value,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [sceq_pkg::IO_WIDTH-1:0]   o_left_out,
    output logic signed [sceq_pkg::IO_WIDTH-1:0]   o_right_out,
    output logic                                   o_last_frame_out,
    output logic                                   o_clipped
);
    import sceq_pkg::*;

    localparam int unsigned SW   = SAMPLE_WIDTH;
    localparam int unsigned CW   = COEF_WIDTH;
    localparam int unsigned BW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int unsigned HW   = BW + 1;
    localparam int unsigned ROWS = 2 * NUM_BANDS;
    localparam int unsigned FRAC = CW - 3;
    localparam int unsigned PW   = SW + CW;
    localparam int unsigned AW   = 64;

    localparam logic signed [AW-1:0] S_HI = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam logic signed [AW-1:0] S_LO = -S_HI - 64'sd1;
    localparam logic signed [AW-1:0] C_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [AW-1:0] C_LO = -C_HI - 64'sd1;
    localparam logic signed [AW-1:0] RND_HALF = 64'sd1 <<< (FRAC - 1);
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW - 1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW - 1){1'b0}}};
    localparam logic signed [CW-1:0] COEF_ONE = CW'(64'd1 << FRAC);

    // Memories.
    logic [CW-1:0]     coef_mem [NUM_BANDS][NUM_TERMS];
    logic [4*SW-1:0]   hist_mem [ROWS];

    logic [NUM_TERMS-1:0] r_coef_vld [NUM_BANDS];
    logic [ROWS-1:0]      r_hist_vld;

    // One coefficient word is read per cycle, registered before its product.
    logic [CW-1:0]        r_coef_rd;
    logic                 r_coef_rd_vld;
    logic                 r_coef_rd_b0;
    logic [4*SW-1:0]      r_hist_rd;
    logic                 r_hist_rd_vld;

    // Working registers.
    logic signed [SW-1:0] r_x_l, r_x_r;
    logic                 r_last;
    logic                 r_clip;
    logic signed [PW-1:0] r_prod;
    logic                 r_prod_sub;
    logic                 r_prod_first;
    logic signed [AW-1:0] r_acc;

    logic                 r_out_vld;
    logic [IO_WIDTH-1:0]  r_left_out, r_right_out;
    logic                 r_last_out, r_clip_out;

    // Combinational.
    logic [BW-1:0]        wr_band;
    logic [BW-1:0]        rd_band;
    logic [HW-1:0]        row;
    logic [TERM_W-1:0]    rd_term;
    logic                 coef_rd;
    logic signed [AW-1:0] l_ext, r_ext, c_ext;
    logic signed [AW-1:0] l_sat, r_sat, c_sat;
    logic signed [CW-1:0] coef_eff;
    logic [4*SW-1:0]      hist_eff;
    logic signed [SW-1:0] h0, h1, h2;
    logic signed [SW-1:0] x_cur;
    logic signed [CW-1:0] m_c;
    logic signed [SW-1:0] m_s;
    logic signed [PW-1:0] prod_c;
    logic signed [AW:0]   add_a, add_b, add_sum;
    logic signed [AW-1:0] add_sat;
    logic signed [AW-1:0] y_full, y_sat;
    logic                 y_clip;
    logic signed [SW-1:0] y;
    logic signed [AW-1:0] out_l_ext, out_r_ext;

    assign wr_band = BW'(i_band_index);
    assign rd_band = BW'(i_cmd.band);
    assign row     = {rd_band, i_cmd.chan};

    // The section read fetches b0; each product step but the last fetches
    // the coefficient of the following term.
    assign rd_term = i_cmd.rd ? TERM_B0 : (i_cmd.term + TERM_W'(1));
    assign coef_rd = i_cmd.rd || (i_cmd.mul && (i_cmd.term != TERM_A2));

    // Input and coefficient saturation to the internal widths.
    assign l_ext = AW'(i_left_in);
    assign r_ext = AW'(i_right_in);
    assign c_ext = AW'(i_coef_value);
    assign l_sat = (l_ext > S_HI) ? S_HI : ((l_ext < S_LO) ? S_LO : l_ext);
    assign r_sat = (r_ext > S_HI) ? S_HI : ((r_ext < S_LO) ? S_LO : r_ext);
    assign c_sat = (c_ext > C_HI) ? C_HI : ((c_ext < C_LO) ? C_LO : c_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr) begin
            coef_mem[wr_band][i_coef_index] <= CW'(c_sat);
        end
        if (coef_rd) begin
            r_coef_rd     <= coef_mem[rd_band][rd_term];
            r_coef_rd_vld <= r_coef_vld[rd_band][rd_term];
            r_coef_rd_b0  <= (rd_term == TERM_B0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            hist_mem[row] <= {h2, y, h0, x_cur};
        end
        if (i_cmd.rd) begin
            r_hist_rd     <= hist_mem[row];
            r_hist_rd_vld <= r_hist_vld[row];
        end
    end

    // Entries never written read as their reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_coef_vld[b] <= '0;
            end
            r_hist_vld <= '0;
        end else begin
            if (i_cmd.coef_wr) begin
                r_coef_vld[wr_band][i_coef_index] <= 1'b1;
                r_hist_vld[{wr_band, 1'b0}]       <= 1'b0;
                r_hist_vld[{wr_band, 1'b1}]       <= 1'b0;
            end
            if (i_cmd.wb) begin
                r_hist_vld[row] <= 1'b1;
            end
        end
    end

    assign coef_eff = r_coef_rd_vld ? r_coef_rd : (r_coef_rd_b0 ? COEF_ONE : '0);

    assign hist_eff = r_hist_rd_vld ? r_hist_rd : '0;
    assign h0       = hist_eff[0*SW +: SW];
    assign h1       = hist_eff[1*SW +: SW];
    assign h2       = hist_eff[2*SW +: SW];
    assign x_cur    = i_cmd.chan ? r_x_r : r_x_l;

    assign m_c = coef_eff;

    always_comb begin
        case (i_cmd.term)
            TERM_B0: m_s = x_cur;
            TERM_B1: m_s = h0;
            TERM_B2: m_s = h1;
            TERM_A1: m_s = h2;
            TERM_A2: m_s = hist_eff[3*SW +: SW];
            default: m_s = x_cur;
        endcase
    end

    assign prod_c = m_c * m_s;

    // Shared saturating adder: product terms, then the rounding constant.
    always_comb begin
        if (i_cmd.rnd) begin
            add_a   = (AW + 1)'(r_acc);
            add_b   = (AW + 1)'(RND_HALF);
            add_sum = add_a + add_b;
        end else begin
            add_a   = r_prod_first ? '0 : (AW + 1)'(r_acc);
            add_b   = (AW + 1)'(r_prod);
            add_sum = r_prod_sub ? (add_a - add_b) : (add_a + add_b);
        end
        if (add_sum[AW] != add_sum[AW-1]) begin
            add_sat = add_sum[AW] ? ACC_MIN : ACC_MAX;
        end else begin
            add_sat = add_sum[AW-1:0];
        end
    end

    assign y_full = r_acc >>> FRAC;
    assign y_clip = (y_full > S_HI) || (y_full < S_LO);
    assign y_sat  = (y_full > S_HI) ? S_HI : ((y_full < S_LO) ? S_LO : y_full);
    assign y      = SW'(y_sat);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_frame) begin
            r_x_l  <= SW'(l_sat);
            r_x_r  <= SW'(r_sat);
            r_last <= i_last_frame;
            r_clip <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod       <= prod_c;
            r_prod_sub   <= (i_cmd.term == TERM_A1) || (i_cmd.term == TERM_A2);
            r_prod_first <= (i_cmd.term == TERM_B0);
        end
        if (i_cmd.acc || i_cmd.rnd) begin
            r_acc <= add_sat;
        end
        if (i_cmd.wb) begin
            if (i_cmd.chan) begin
                r_x_r <= y;
            end else begin
                r_x_l <= y;
            end
            r_clip <= r_clip | y_clip;
        end
    end

    // Output register.
    assign out_l_ext = AW'(r_x_l);
    assign out_r_ext = AW'(r_x_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_left_out  <= out_l_ext[IO_WIDTH-1:0];
            r_right_out <= out_r_ext[IO_WIDTH-1:0];
            r_last_out  <= r_last;
            r_clip_out  <= r_clip;
        end
    end

    assign o_status.out_free = !r_out_vld || !i_out_stall;
    assign o_out_valid       = r_out_vld;
    assign o_left_out        = r_left_out;
    assign o_right_out       = r_right_out;
    assign o_last_frame_out  = r_last_out;
    assign o_clipped         = r_clip_out;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo cascaded biquad equaliser. Requests are
// queued by a scenario block and driven with random gaps. Returned frames are
// taken with random stalls and compared field by field against a bit-true
// model of the band chain that the bench keeps alongside the block.
// ----------------------------------------------------------------------------
module tb;
    import sceq_pkg::*;

    localparam int     NB       = DEF_NUM_BANDS;
    localparam int     FRAC     = DEF_COEF_WIDTH - 3;
    localparam longint SAMP_MAX = (64'sd1 <<< (DEF_SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMP_MIN = -SAMP_MAX - 1;
    // The pause before a register write leaves a comfortable margin beyond the
    // longest frame.
    localparam int     SETTLE   = 18 * NB + 2 + 60;

    localparam logic signed [IO_WIDTH-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [IO_WIDTH-1:0] Q_MIN = 24'sh800000;
    localparam logic signed [IO_WIDTH-1:0] UNITY = 24'sh200000;

    // One request as the host would issue it.
    typedef struct {
        logic                         op;
        logic signed [IO_WIDTH-1:0]   left;
        logic signed [IO_WIDTH-1:0]   right;
        logic                         last;
        logic [BAND_IN_W-1:0]         band;
        logic [COEF_IDX_W-1:0]        term;
        logic signed [IO_WIDTH-1:0]   coef;
    } t_eq_req;

    // One filtered stereo frame.
    typedef struct {
        logic signed [IO_WIDTH-1:0]   left;
        logic signed [IO_WIDTH-1:0]   right;
        logic                         last;
        logic                         clip;
    } t_eq_frame;

    // Every input has a known value from time zero.
    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic                         i_opcode      = OP_FRAME;
    logic signed [IO_WIDTH-1:0]   i_left_in     = '0;
    logic signed [IO_WIDTH-1:0]   i_right_in    = '0;
    logic                         i_last_frame  = 1'b0;
    logic [BAND_IN_W-1:0]         i_band_index  = '0;
    logic [COEF_IDX_W-1:0]        i_coef_index  = '0;
    logic signed [IO_WIDTH-1:0]   i_coef_value  = '0;
    logic                         i_out_stall   = 1'b0;
    logic                         i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index   = CFG_ENABLE;
    logic [CFG_DATA_W-1:0]        i_cfg_data    = '0;

    logic                         o_in_stall;
    logic                         o_out_valid;
    logic signed [IO_WIDTH-1:0]   o_left_out;
    logic signed [IO_WIDTH-1:0]   o_right_out;
    logic                         o_last_frame_out;
    logic                         o_clipped;

    stereo_cascaded_biquad_eq DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_left_in        (i_left_in),
        .i_right_in       (i_right_in),
        .i_last_frame     (i_last_frame),
        .i_band_index     (i_band_index),
        .i_coef_index     (i_coef_index),
        .i_coef_value     (i_coef_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_last_frame_out (o_last_frame_out),
        .o_clipped        (o_clipped),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Equaliser model: its own copy of the registers, the coefficient store
    // (five terms per band) and the section history (x1, x2, y1, y2 for each
    // channel of each band).
    // ------------------------------------------------------------------------
    bit                    eq_enable;
    logic [CFG_DATA_W-1:0] eq_band_count;
    longint                coef_store [5 * NB];
    longint                band_hist  [8 * NB];
    bit                    frame_clip;

    t_eq_req   pending_reqs[$];
    t_eq_frame expected_frames[$];
    int        queued_count   = 0;
    int        accepted_count = 0;
    int        mismatches     = 0;
    bit        no_idle        = 1'b0;

    function automatic void reset_eq_model();
        int k;
        eq_enable     = RST_ENABLE;
        eq_band_count = RST_ACTIVE_BANDS;
        for (k = 0; k < 5 * NB; k++)
            coef_store[k] = 0;
        for (k = 0; k < 8 * NB; k++)
            band_hist[k] = 0;
        for (k = 0; k < NB; k++)
            coef_store[k * 5 + TERM_B0] = longint'(1) <<< FRAC;
    endfunction

    // One direct-form-I section on one channel. The five products are exact and
    // their sum cannot approach the 64-bit limits, so the accumulator needs no
    // saturation. Rounding adds half an LSB and then floors.
    function automatic longint run_section(int band, int chan, longint x);
        longint acc;
        longint y;
        int     c;
        int     h;
        c   = band * 5;
        h   = band * 8 + chan * 4;
        acc = coef_store[c + TERM_B0] * x
            + coef_store[c + TERM_B1] * band_hist[h]
            + coef_store[c + TERM_B2] * band_hist[h + 1]
            - coef_store[c + TERM_A1] * band_hist[h + 2]
            - coef_store[c + TERM_A2] * band_hist[h + 3];
        acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (acc > SAMP_MAX) begin
            y          = SAMP_MAX;
            frame_clip = 1'b1;
        end else if (acc < SAMP_MIN) begin
            y          = SAMP_MIN;
            frame_clip = 1'b1;
        end else begin
            y = acc;
        end
        band_hist[h + 1] = band_hist[h];
        band_hist[h]     = x;
        band_hist[h + 3] = band_hist[h + 2];
        band_hist[h + 2] = y;
        return y;
    endfunction

    // Applies one accepted request to the model and queues the frame it yields.
    function automatic void apply_request(t_eq_req r);
        t_eq_frame f;
        longint    l;
        longint    rt;
        int        n;
        int        k;
        if (r.op == OP_COEF) begin
            // A term code beyond a2 is dropped, history included.
            if (r.term <= TERM_A2 && r.band < NB) begin
                coef_store[r.band * 5 + r.term] = longint'(r.coef);
                for (k = 0; k < 8; k++)
                    band_hist[r.band * 8 + k] = 0;
            end
            return;
        end
        l          = r.left;
        rt         = r.right;
        frame_clip = 1'b0;
        if (eq_enable) begin
            n = (eq_band_count > NB) ? NB : int'(eq_band_count);
            for (k = 0; k < n; k++) begin
                l  = run_section(k, 0, l);
                rt = run_section(k, 1, rt);
            end
        end
        f.left  = l[IO_WIDTH-1:0];
        f.right = rt[IO_WIDTH-1:0];
        f.last  = r.last;
        f.clip  = frame_clip;
        expected_frames.insert(expected_frames.size(), f);
    endfunction

    task automatic flag_mismatch(string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Each side idles in roughly 18 percent of its cycles, except during the
    // stretch where idling is switched off.
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 18);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A request is held, payload unchanged, until the block
    // takes it; the model is updated at the edge of acceptance.
    // ------------------------------------------------------------------------
    t_eq_req on_wire;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_request(on_wire);
                accepted_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() != 0 && !idle_now()) begin
                    on_wire       = pending_reqs.pop_front();
                    i_in_valid   <= 1'b1;
                    i_opcode     <= on_wire.op;
                    i_left_in    <= on_wire.left;
                    i_right_in   <= on_wire.right;
                    i_last_frame <= on_wire.last;
                    i_band_index <= on_wire.band;
                    i_coef_index <= on_wire.term;
                    i_coef_value <= on_wire.coef;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every frame taken is checked against the oldest one
    // predicted, and the stall is redrawn each cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_eq_frame want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    flag_mismatch("frame returned with none outstanding");
                end else begin
                    want = expected_frames.pop_front();
                    if (o_left_out !== want.left)
                        flag_mismatch($sformatf("left_out %0d, expected %0d",
                                                o_left_out, want.left));
                    if (o_right_out !== want.right)
                        flag_mismatch($sformatf("right_out %0d, expected %0d",
                                                o_right_out, want.right));
                    if (o_last_frame_out !== want.last)
                        flag_mismatch($sformatf("last_frame_out %b, expected %b",
                                                o_last_frame_out, want.last));
                    if (o_clipped !== want.clip)
                        flag_mismatch($sformatf("clipped %b, expected %b",
                                                o_clipped, want.clip));
                end
            end
            i_out_stall <= idle_now();
        end
    end

    // ------------------------------------------------------------------------
    // Request builders. Fields that the operation ignores are still randomised
    // so that every input bit toggles.
    // ------------------------------------------------------------------------
    function automatic void push_frame(logic signed [IO_WIDTH-1:0] l,
                                       logic signed [IO_WIDTH-1:0] r, logic last);
        t_eq_req q;
        q.op    = OP_FRAME;
        q.left  = l;
        q.right = r;
        q.last  = last;
        q.band  = BAND_IN_W'($urandom);
        q.term  = COEF_IDX_W'($urandom);
        q.coef  = IO_WIDTH'($urandom);
        pending_reqs.insert(pending_reqs.size(), q);
        queued_count++;
    endfunction

    function automatic void push_coef(logic [BAND_IN_W-1:0] band,
                                      logic [COEF_IDX_W-1:0] term,
                                      logic signed [IO_WIDTH-1:0] value);
        t_eq_req q;
        q.op    = OP_COEF;
        q.left  = IO_WIDTH'($urandom);
        q.right = IO_WIDTH'($urandom);
        q.last  = 1'($urandom);
        q.band  = band;
        q.term  = term;
        q.coef  = value;
        pending_reqs.insert(pending_reqs.size(), q);
        queued_count++;
    endfunction

    // Samples: mostly full range, with the extremes and quiet material mixed in.
    function automatic logic signed [IO_WIDTH-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return IO_WIDTH'(int'($urandom_range(0, 524288)) - 262144);
            default: return IO_WIDTH'($urandom);
        endcase
    endfunction

    // Coefficients: most lie within +-0.5, which keeps a section stable so that
    // the history carries real signal; the rest cover the whole Q2.21 range.
    function automatic logic signed [IO_WIDTH-1:0] pick_coef();
        if ($urandom_range(9) < 3)
            return IO_WIDTH'($urandom);
        return IO_WIDTH'(int'($urandom_range(0, 2097152)) - 1048576);
    endfunction

    task automatic queue_random(int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 8) begin
                if ($urandom_range(9) == 0)
                    push_coef(BAND_IN_W'($urandom),
                              COEF_IDX_W'($urandom_range(TERM_A2 + 1,
                                                         (1 << COEF_IDX_W) - 1)),
                              pick_coef());
                else
                    push_coef(BAND_IN_W'($urandom),
                              COEF_IDX_W'($urandom_range(TERM_B0, TERM_A2)),
                              pick_coef());
            end else begin
                push_frame(pick_sample(), pick_sample(), $urandom_range(7) == 0);
            end
        end
    endtask

    // Registers are only written while the block is idle; the model follows
    // at once since nothing is in flight.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_ENABLE)
            eq_enable = val[0];
        else
            eq_band_count = val;
        @(posedge i_clk);
    endtask

    // Holds the scenario until every queued request has been taken and every
    // frame returned, then lets the block settle.
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Scenario.
    // ------------------------------------------------------------------------
    initial begin
        reset_eq_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset settings: all eight bands at unity
        // first, so the extremes must come back untouched.
        push_frame(Q_MAX, Q_MIN, 1'b1);
        push_frame(Q_MIN, Q_MAX, 1'b0);
        push_frame('0, '0, 1'b0);
        push_frame(-24'sd1, 24'sd1, 1'b1);
        // Gain of nearly four on band zero makes full-scale input clip.
        push_coef(3'd0, TERM_B0, Q_MAX);
        // Term codes past a2 must neither load nor clear anything.
        push_coef(3'd0, COEF_IDX_W'(TERM_A2 + 1), 24'sh123456);
        push_coef(3'd7, COEF_IDX_W'((1 << COEF_IDX_W) - 1), Q_MIN);
        push_frame(Q_MAX, Q_MIN, 1'b0);
        push_frame(24'sh100000, -24'sh100000, 1'b0);
        // One value for each of the other terms, on different bands, extreme for all but a1.
        push_coef(3'd1, TERM_B1, Q_MIN);
        push_coef(3'd2, TERM_B2, Q_MAX);
        push_coef(3'd3, TERM_A1, 24'sh100000);
        push_coef(3'd4, TERM_A2, Q_MIN);
        push_frame(24'sh400000, -24'sh400000, 1'b0);
        push_frame(24'sh001000, 24'sh7FF000, 1'b1);
        push_frame(-24'sh001000, '0, 1'b0);
        push_frame(Q_MAX, Q_MAX, 1'b1);
        // Put the touched terms back to a clean unity chain.
        push_coef(3'd0, TERM_B0, UNITY);
        push_coef(3'd1, TERM_B1, '0);
        push_coef(3'd2, TERM_B2, '0);
        push_coef(3'd3, TERM_A1, '0);
        push_coef(3'd4, TERM_A2, '0);
        push_frame(24'sh0ABCDE, -24'sh0ABCDE, 1'b1);
        wait_drained();

        // Full chain, both registers written explicitly.
        write_reg(CFG_ENABLE, {(CFG_DATA_W - 1)'($urandom), 1'b1});
        write_reg(CFG_ACTIVE_BANDS, 4'd8);
        queue_random(300);
        wait_drained();

        // A single band, run without any idling on either side.
        write_reg(CFG_ACTIVE_BANDS, 4'd1);
        no_idle = 1'b1;
        queue_random(300);
        wait_drained();
        no_idle = 1'b0;

        // Pass-through: frames come back unchanged and history is left alone.
        write_reg(CFG_ENABLE, {(CFG_DATA_W - 1)'($urandom), 1'b0});
        queue_random(150);
        wait_drained();

        // Enabled again but with no band applied.
        write_reg(CFG_ENABLE, {(CFG_DATA_W - 1)'($urandom), 1'b1});
        write_reg(CFG_ACTIVE_BANDS, 4'd0);
        queue_random(150);
        wait_drained();

        // A band count beyond the chain length is limited to the chain.
        write_reg(CFG_ACTIVE_BANDS, 4'd15);
        queue_random(300);
        wait_drained();

        write_reg(CFG_ACTIVE_BANDS, CFG_DATA_W'($urandom_range(2, 7)));
        queue_random(350);
        wait_drained();

        write_reg(CFG_ACTIVE_BANDS, CFG_DATA_W'($urandom_range(1, 8)));
        queue_random(350);
        wait_drained();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, set well beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
